// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge; the property itself must be safe across reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cmag_pkg.sv =====
package cmag_pkg;

  localparam int LANES      = 2;
  localparam int ITERATIONS = 16;
  localparam int COMP_W     = 28;
  localparam int MAG_W      = 28;
  localparam int FRAC_BITS  = 12;
  localparam int GAIN_W     = 12;

  // 0.607252935 truncated to 12 fractional bits
  localparam logic [GAIN_W-1:0] GAIN_Q12 = 12'd2487;

  // abs << FRAC_BITS plus headroom for the CORDIC gain and a sign bit
  localparam int XW     = COMP_W + FRAC_BITS + 3;
  localparam int PROD_W = XW - 1 + GAIN_W;
  localparam int SCL_W  = PROD_W - 2 * FRAC_BITS;
  localparam int LAST   = ITERATIONS - 1;

  // input register + one stage per iteration + gain/saturate stage
  localparam int LATENCY = ITERATIONS + 2;

  localparam logic MODE_CORDIC = 1'b0;
  localparam logic MODE_AMBM   = 1'b1;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [COMP_W-1:0]        ucomp_t;
  typedef logic signed [XW-1:0]     acc_t;
  typedef logic [MAG_W-1:0]         mag_t;

  typedef struct packed {
    logic valid;
    logic mode;
    logic frame_end;
  } ctl_t;

endpackage

// ===== design/complex_magnitude_cordic_lanes.sv =====
// Two-lane complex magnitude: CORDIC vectoring or alpha-max-beta-min per register.
// A request taken at a clock edge shows its result on done_o after the input
// register, 16 iteration stages and the gain/saturate stage.
// Throughput: one request per cycle; busy_o stays low and the receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets the mode to CORDIC.
`include "assert_macros.svh"

module complex_magnitude_cordic_lanes (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              magnitude_mode_we_i,
  input  logic              magnitude_mode_i,
  input  cmag_pkg::comp_t   lane0_real_i,
  input  cmag_pkg::comp_t   lane0_imag_i,
  input  cmag_pkg::comp_t   lane1_real_i,
  input  cmag_pkg::comp_t   lane1_imag_i,
  input  logic              frame_end_in_i,
  output logic              done_o,
  output cmag_pkg::mag_t    lane0_mag_o,
  output cmag_pkg::mag_t    lane1_mag_o,
  output logic              frame_end_out_o
);

  logic            mode_q;
  cmag_pkg::ctl_t  req_ctl;
  cmag_pkg::ctl_t  pre_ctl;
  cmag_pkg::ctl_t  cor_ctl;
  cmag_pkg::ctl_t  out_ctl;
  cmag_pkg::comp_t re  [cmag_pkg::LANES];
  cmag_pkg::comp_t im  [cmag_pkg::LANES];
  cmag_pkg::acc_t  pre_x [cmag_pkg::LANES];
  cmag_pkg::acc_t  pre_y [cmag_pkg::LANES];
  cmag_pkg::acc_t  cor_x [cmag_pkg::LANES];
  cmag_pkg::mag_t  mag [cmag_pkg::LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cmag_pkg::MODE_CORDIC;
    end else if (magnitude_mode_we_i) begin
      mode_q <= magnitude_mode_i;
    end
  end

  assign busy_o = 1'b0;

  assign req_ctl.valid     = start_i && !busy_o;
  assign req_ctl.mode      = mode_q;
  assign req_ctl.frame_end = frame_end_in_i;

  assign re[0] = lane0_real_i;
  assign im[0] = lane0_imag_i;
  assign re[1] = lane1_real_i;
  assign im[1] = lane1_imag_i;

  cmag_pre u_pre (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (req_ctl),
    .re_i   (re),
    .im_i   (im),
    .ctl_o  (pre_ctl),
    .x_o    (pre_x),
    .y_o    (pre_y)
  );

  cmag_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pre_ctl),
    .x_i    (pre_x),
    .y_i    (pre_y),
    .ctl_o  (cor_ctl),
    .x_o    (cor_x)
  );

  cmag_post u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cor_ctl),
    .x_i    (cor_x),
    .ctl_o  (out_ctl),
    .mag_o  (mag)
  );

  assign done_o          = out_ctl.valid;
  assign frame_end_out_o = out_ctl.frame_end;
  assign lane0_mag_o     = mag[0];
  assign lane1_mag_o     = mag[1];

  `ASSERT_RST(a_req_to_done, clk_i, rst_ni, (start_i && !busy_o) |-> ##(cmag_pkg::LATENCY) done_o, "request lost in pipeline")
  `ASSERT_RST(a_done_has_req, clk_i, rst_ni, done_o |-> $past(start_i && !busy_o, cmag_pkg::LATENCY), "result without request")

endmodule

// ===== design/cmag_pre.sv =====
module cmag_pre (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmag_pkg::ctl_t           ctl_i,
  input  cmag_pkg::comp_t          re_i  [cmag_pkg::LANES],
  input  cmag_pkg::comp_t          im_i  [cmag_pkg::LANES],
  output cmag_pkg::ctl_t           ctl_o,
  output cmag_pkg::acc_t           x_o   [cmag_pkg::LANES],
  output cmag_pkg::acc_t           y_o   [cmag_pkg::LANES]
);

  cmag_pkg::ctl_t ctl_q;
  cmag_pkg::acc_t x_q [cmag_pkg::LANES];
  cmag_pkg::acc_t y_q [cmag_pkg::LANES];
  cmag_pkg::acc_t x_d [cmag_pkg::LANES];
  cmag_pkg::acc_t y_d [cmag_pkg::LANES];

  localparam int PAD_W = cmag_pkg::XW - cmag_pkg::COMP_W - cmag_pkg::FRAC_BITS;

  // Most negative value negates to 2^(COMP_W-1), which still fits unsigned.
  function automatic cmag_pkg::ucomp_t abs_val(input cmag_pkg::comp_t v);
    cmag_pkg::ucomp_t r;
    if (v[cmag_pkg::COMP_W-1]) begin
      r = ~cmag_pkg::ucomp_t'(v) + cmag_pkg::ucomp_t'(1);
    end else begin
      r = cmag_pkg::ucomp_t'(v);
    end
    return r;
  endfunction

  always_comb begin
    for (int l = 0; l < cmag_pkg::LANES; l++) begin
      x_d[l] = cmag_pkg::acc_t'({{PAD_W{1'b0}}, abs_val(re_i[l]),
                                 {cmag_pkg::FRAC_BITS{1'b0}}});
      y_d[l] = cmag_pkg::acc_t'({{PAD_W{1'b0}}, abs_val(im_i[l]),
                                 {cmag_pkg::FRAC_BITS{1'b0}}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;

endmodule

// ===== design/cmag_cordic.sv =====
`include "assert_macros.svh"

module cmag_cordic (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmag_pkg::ctl_t           ctl_i,
  input  cmag_pkg::acc_t           x_i   [cmag_pkg::LANES],
  input  cmag_pkg::acc_t           y_i   [cmag_pkg::LANES],
  output cmag_pkg::ctl_t           ctl_o,
  output cmag_pkg::acc_t           x_o   [cmag_pkg::LANES]
);

  cmag_pkg::ctl_t ctl_q [cmag_pkg::ITERATIONS];
  cmag_pkg::acc_t x_q   [cmag_pkg::ITERATIONS][cmag_pkg::LANES];
  cmag_pkg::acc_t y_q   [cmag_pkg::ITERATIONS][cmag_pkg::LANES];

  localparam int AMBM_W = cmag_pkg::COMP_W + 1;

  // max + min/4 + min/8 on the unscaled absolute values
  function automatic cmag_pkg::acc_t ambm(input cmag_pkg::ucomp_t a,
                                          input cmag_pkg::ucomp_t b);
    cmag_pkg::ucomp_t   mx;
    cmag_pkg::ucomp_t   mn;
    logic [AMBM_W-1:0]  sum;
    mx  = (a > b) ? a : b;
    mn  = (a > b) ? b : a;
    sum = {1'b0, mx} + {1'b0, (mn >> 2)} + {1'b0, (mn >> 3)};
    return cmag_pkg::acc_t'({{(cmag_pkg::XW-AMBM_W){1'b0}}, sum});
  endfunction

  for (genvar s = 0; s < cmag_pkg::ITERATIONS; s++) begin : g_stage
    cmag_pkg::ctl_t ctl_in;
    cmag_pkg::acc_t x_in [cmag_pkg::LANES];
    cmag_pkg::acc_t y_in [cmag_pkg::LANES];
    cmag_pkg::acc_t x_d  [cmag_pkg::LANES];
    cmag_pkg::acc_t y_d  [cmag_pkg::LANES];

    if (s == 0) begin : g_head
      assign ctl_in = ctl_i;
      assign x_in   = x_i;
      assign y_in   = y_i;
    end else begin : g_body
      assign ctl_in = ctl_q[s-1];
      assign x_in   = x_q[s-1];
      assign y_in   = y_q[s-1];
    end

    always_comb begin
      for (int l = 0; l < cmag_pkg::LANES; l++) begin
        if (ctl_in.mode == cmag_pkg::MODE_AMBM) begin
          // approximation is done in the first stage, later stages carry it
          if (s == 0) begin
            x_d[l] = ambm(x_in[l][cmag_pkg::FRAC_BITS+cmag_pkg::COMP_W-1:cmag_pkg::FRAC_BITS],
                          y_in[l][cmag_pkg::FRAC_BITS+cmag_pkg::COMP_W-1:cmag_pkg::FRAC_BITS]);
            y_d[l] = '0;
          end else begin
            x_d[l] = x_in[l];
            y_d[l] = y_in[l];
          end
        end else if (!y_in[l][cmag_pkg::XW-1] && (y_in[l] != '0)) begin
          x_d[l] = x_in[l] + (y_in[l] >>> s);
          y_d[l] = y_in[l] - (x_in[l] >>> s);
        end else begin
          // zero y rotates the other way
          x_d[l] = x_in[l] - (y_in[l] >>> s);
          y_d[l] = y_in[l] + (x_in[l] >>> s);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else begin
        ctl_q[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[s] <= x_d;
      y_q[s] <= y_d;
    end
  end

  assign ctl_o = ctl_q[cmag_pkg::LAST];
  assign x_o   = x_q[cmag_pkg::LAST];

  for (genvar l = 0; l < cmag_pkg::LANES; l++) begin : g_chk
    `ASSERT_RST(a_ambm_y_zero, clk_i, rst_ni, (ctl_q[cmag_pkg::LAST].valid && (ctl_q[cmag_pkg::LAST].mode == cmag_pkg::MODE_AMBM)) |-> (y_q[cmag_pkg::LAST][l] == '0), "approximation request left residue in y")
  end

endmodule

// ===== design/cmag_post.sv =====
`include "assert_macros.svh"

module cmag_post (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmag_pkg::ctl_t           ctl_i,
  input  cmag_pkg::acc_t           x_i   [cmag_pkg::LANES],
  output cmag_pkg::ctl_t           ctl_o,
  output cmag_pkg::mag_t           mag_o [cmag_pkg::LANES]
);

  cmag_pkg::ctl_t ctl_q;
  cmag_pkg::mag_t mag_q [cmag_pkg::LANES];
  cmag_pkg::mag_t mag_d [cmag_pkg::LANES];

  // gain multiply and floor in CORDIC mode (AMBM passes x through), clamp negative to zero, saturate
  function automatic cmag_pkg::mag_t finish(input cmag_pkg::acc_t x, input logic mode);
    logic [cmag_pkg::PROD_W-1:0] prod;
    logic [cmag_pkg::XW-1:0]     cand;
    prod = {{cmag_pkg::GAIN_W{1'b0}}, x[cmag_pkg::XW-2:0]} *
           {{(cmag_pkg::XW-1){1'b0}}, cmag_pkg::GAIN_Q12};
    if (mode == cmag_pkg::MODE_AMBM) begin
      cand = x;
    end else if (x[cmag_pkg::XW-1]) begin
      cand = '0;
    end else begin
      cand = {{(cmag_pkg::XW-cmag_pkg::SCL_W){1'b0}},
              prod[cmag_pkg::PROD_W-1:2*cmag_pkg::FRAC_BITS]};
    end
    if (|cand[cmag_pkg::XW-1:cmag_pkg::MAG_W]) begin
      return '1;
    end
    return cand[cmag_pkg::MAG_W-1:0];
  endfunction

  always_comb begin
    for (int l = 0; l < cmag_pkg::LANES; l++) begin
      mag_d[l] = finish(x_i[l], ctl_i.mode);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

  assign ctl_o = ctl_q;
  assign mag_o = mag_q;

  // x only grows from a non-negative start, so the clamp to zero never fires
  for (genvar l = 0; l < cmag_pkg::LANES; l++) begin : g_chk
    `ASSERT_ALWAYS(a_x_nonneg, clk_i, (ctl_i.valid && (ctl_i.mode == cmag_pkg::MODE_CORDIC)) |-> !x_i[l][cmag_pkg::XW-1], "CORDIC x went negative")
  end

endmodule
